// ===== rtl/core/cjd_pkg.sv =====
// Package for the calendar / Julian day number converter.
// Field widths, calendar constants and fixed-point reciprocals.
// No dependencies.
package cjd_pkg;

  // Port field widths
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DOM_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned DAYN_W  = 23;
  localparam int unsigned SOD_W   = 17;

  // Register stages from request to result strobe
  localparam int unsigned PIPE_DEPTH = 12;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  localparam logic [22:0] DAY_BASE  = 23'd1721119;
  localparam logic [23:0] FIRST_DAY = 24'd1721426;  // 0001-01-01
  localparam logic [23:0] LAST_DAY  = 24'd5373484;  // 9999-12-31

  localparam logic [17:0] ERA_DAYS  = 18'd146097;   // days in 400 years
  localparam logic [10:0] QUAD_DAYS = 11'd1461;     // days in 4 years
  localparam logic [7:0]  MON_SPAN  = 8'd153;       // days in 5 months from March
  localparam logic [6:0]  CENTURY   = 7'd100;

  // floor(-146097 / 4) mod 2^23, the era term for year -1
  localparam logic [22:0] NEG_ERA_TERM = 23'd8352083;

  // Rounded-up reciprocals; floor(x/d) = (x * R) >> S over the used range
  localparam logic [12:0] RECIP_Y100 = 13'd5243;      // /100,    S=19
  localparam logic [23:0] RECIP_ERA  = 24'd15051803;  // /146097, S=41
  localparam logic [19:0] RECIP_QUAD = 20'd734937;    // /1461,   S=30
  localparam logic [12:0] RECIP_MON  = 13'd6854;      // /153,    S=20
  localparam logic [16:0] RECIP_HOUR = 17'd74566;     // /3600,   S=28
  localparam logic [12:0] RECIP_MIN  = 13'd4370;      // /60,     S=18
  localparam logic [7:0]  RECIP_FIVE = 8'd205;        // /5,      S=10

  // Days before month index mp, March = 0: floor((153*mp + 2) / 5)
  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    logic [8:0] res;
    unique case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      4'd12:   res = 9'd367;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/calendar_julian_day_convert.sv =====
// Gregorian calendar <-> civil Julian day number converter, fully pipelined.
// Depends on cjd_pkg (widths, constants, reciprocals, month offset table).
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. busy is
//   always low: the pipeline takes one request in every cycle, back to back.
//   mode 0 converts year/month/day_of_month/hour_in/minute_in/second_in to
//   day_number and seconds_of_day. mode 1 converts day_number_in and
//   seconds_of_day_in to year_out .. second_out; a day outside years 1..9999
//   sets range_error and zeroes the calendar fields. Fields of the other
//   mode read as zero. A time of day of a full day or more rolls one day on.
//   done is high for one cycle, with the result on the output ports in that
//   same cycle.
//   Throughput: one request per clock. The depth is set by the chain of
//   reciprocal multiplies for the era / 4-year / month split of mode 1,
//   each multiply followed by a register.
//   The receiver cannot stall; a result not taken in its done cycle is gone.
//   Reset (rst, synchronous) clears the stage valid bits, so nothing in
//   flight is reported; the data path itself is not reset.
module calendar_julian_day_convert (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [cjd_pkg::YEAR_W-1:0]    year,
  input  logic [cjd_pkg::MONTH_W-1:0]   month,
  input  logic [cjd_pkg::DOM_W-1:0]     day_of_month,
  input  logic [cjd_pkg::HOUR_W-1:0]    hour_in,
  input  logic [cjd_pkg::MIN_W-1:0]     minute_in,
  input  logic [cjd_pkg::SEC_W-1:0]     second_in,
  input  logic [cjd_pkg::DAYN_W-1:0]    day_number_in,
  input  logic [cjd_pkg::SOD_W-1:0]     seconds_of_day_in,
  output logic                          done,
  output logic [cjd_pkg::DAYN_W-1:0]    day_number,
  output logic [cjd_pkg::SOD_W-1:0]     seconds_of_day,
  output logic [cjd_pkg::YEAR_W-1:0]    year_out,
  output logic [cjd_pkg::MONTH_W-1:0]   month_out,
  output logic [cjd_pkg::DOM_W-1:0]     day_out,
  output logic [cjd_pkg::HOUR_W-1:0]    hour_out,
  output logic [cjd_pkg::MIN_W-1:0]     minute_out,
  output logic [cjd_pkg::SEC_W-1:0]     second_out,
  output logic                          range_error
);
  import cjd_pkg::*;

  // No back-pressure anywhere in the pipe
  assign busy = 1'b0;

  // Valid bit per stage; bit k belongs to stage k+1
  logic [PIPE_DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], start & ~busy};
    end
  end

  assign done = vld[PIPE_DEPTH-1];

  // Mode bit follows the request down the pipe
  logic s1_mode, s2_mode, s3_mode, s4_mode, s5_mode, s6_mode;
  logic s7_mode, s8_mode, s9_mode, s10_mode, s11_mode;

  // ------------------------------------------------------------------
  // Stage 1: month shift to a March-based year, raw time sum,
  //          seconds wrap and day carry for mode 1.
  // ------------------------------------------------------------------
  logic        early_c;     // January or February (or month 0)
  logic [13:0] ya_c;
  logic        yneg_c;
  logic [3:0]  mp_c;
  logic [16:0] tsum_c;
  logic        wrap_c;
  logic [16:0] sec1_c;
  logic [23:0] day1_c;

  always_comb begin
    early_c = (month <= 4'd2);
    ya_c    = early_c ? year - 14'd1 : year;
    yneg_c  = early_c && (year == '0);     // year 0 Jan/Feb -> year -1
    mp_c    = early_c ? month + 4'd9 : month - 4'd3;
    tsum_c  = 17'(hour_in) * SECS_PER_HOUR + 17'(minute_in) * SECS_PER_MIN
              + 17'(second_in);
    wrap_c  = (seconds_of_day_in >= SECS_PER_DAY);
    sec1_c  = wrap_c ? seconds_of_day_in - SECS_PER_DAY : seconds_of_day_in;
    day1_c  = {1'b0, day_number_in} + 24'(wrap_c);
  end

  logic [13:0] s1_ya;
  logic        s1_yneg;
  logic [8:0]  s1_mterm;
  logic [4:0]  s1_dom;
  logic [16:0] s1_tsum;
  logic [16:0] s1_sec;
  logic [23:0] s1_day;

  always_ff @(posedge clk) begin
    s1_mode  <= mode;
    s1_ya    <= ya_c;
    s1_yneg  <= yneg_c;
    s1_mterm <= month_offset(mp_c);
    s1_dom   <= day_of_month;
    s1_tsum  <= tsum_c;
    s1_sec   <= sec1_c;
    s1_day   <= day1_c;
  end

  // ------------------------------------------------------------------
  // Stage 2: year * 1/100, time-of-day wrap; range check and
  //          4j-1 for mode 1.
  // ------------------------------------------------------------------
  logic [23:0] j_c;

  assign j_c = s1_day - {1'b0, DAY_BASE};

  logic [26:0] s2_prod_y;
  logic [13:0] s2_ya;
  logic        s2_yneg;
  logic [8:0]  s2_mterm;
  logic [4:0]  s2_dom;
  logic        s2_carry;
  logic [16:0] s2_secs;
  logic        s2_err;
  logic [23:0] s2_x1;
  logic [16:0] s2_sec;

  always_ff @(posedge clk) begin
    s2_mode   <= s1_mode;
    s2_prod_y <= 27'(s1_ya) * 27'(RECIP_Y100);
    s2_ya     <= s1_ya;
    s2_yneg   <= s1_yneg;
    s2_mterm  <= s1_mterm;
    s2_dom    <= s1_dom;
    s2_carry  <= (s1_tsum >= SECS_PER_DAY);
    s2_secs   <= (s1_tsum >= SECS_PER_DAY) ? s1_tsum - SECS_PER_DAY : s1_tsum;
    s2_err    <= (s1_day < FIRST_DAY) || (s1_day > LAST_DAY);
    s2_x1     <= {j_c[21:0], 2'b00} - 24'd1;
    s2_sec    <= s1_sec;
  end

  // ------------------------------------------------------------------
  // Stage 3: century c -> 100c and 146097c; era and hour reciprocals.
  // ------------------------------------------------------------------
  logic [7:0] cent_c;

  assign cent_c = s2_prod_y[26:19];

  logic [13:0] s3_c100;
  logic [24:0] s3_c146;
  logic [13:0] s3_ya;
  logic        s3_yneg;
  logic [8:0]  s3_mterm;
  logic [4:0]  s3_dom;
  logic        s3_carry;
  logic [16:0] s3_secs;
  logic [47:0] s3_prod_q;
  logic [33:0] s3_prod_h;
  logic        s3_err;
  logic [23:0] s3_x1;
  logic [16:0] s3_sec;

  always_ff @(posedge clk) begin
    s3_mode   <= s2_mode;
    s3_c100   <= 14'(cent_c) * 14'(CENTURY);
    s3_c146   <= 25'(cent_c) * 25'(ERA_DAYS);
    s3_ya     <= s2_ya;
    s3_yneg   <= s2_yneg;
    s3_mterm  <= s2_mterm;
    s3_dom    <= s2_dom;
    s3_carry  <= s2_carry;
    s3_secs   <= s2_secs;
    s3_prod_q <= 48'(s2_x1) * 48'(RECIP_ERA);
    s3_prod_h <= 34'(s2_sec) * 34'(RECIP_HOUR);
    s3_err    <= s2_err;
    s3_x1     <= s2_x1;
    s3_sec    <= s2_sec;
  end

  // ------------------------------------------------------------------
  // Stage 4: year in century, era term, constant part of the sum;
  //          era count q -> 146097q, hour -> 3600*hour.
  // ------------------------------------------------------------------
  logic [13:0] yrem_c;
  logic [6:0]  q_c;
  logic [4:0]  hour_c;

  always_comb begin
    yrem_c = s3_ya - s3_c100;
    q_c    = s3_prod_q[47:41];
    hour_c = s3_prod_h[32:28];
  end

  logic [6:0]  s4_yr;
  logic [22:0] s4_tc;
  logic [22:0] s4_acc;
  logic [16:0] s4_secs;
  logic [6:0]  s4_q;
  logic [23:0] s4_qm;
  logic [4:0]  s4_hour;
  logic [16:0] s4_h3600;
  logic        s4_err;
  logic [23:0] s4_x1;
  logic [16:0] s4_sec;

  always_ff @(posedge clk) begin
    s4_mode  <= s3_mode;
    s4_yr    <= s3_yneg ? 7'd99 : yrem_c[6:0];
    s4_tc    <= s3_yneg ? NEG_ERA_TERM : s3_c146[24:2];
    s4_acc   <= 23'(s3_dom) + 23'(s3_mterm) + DAY_BASE + 23'(s3_carry);
    s4_secs  <= s3_secs;
    s4_q     <= q_c;
    s4_qm    <= 24'(q_c) * 24'(ERA_DAYS);
    s4_hour  <= hour_c;
    s4_h3600 <= 17'(hour_c) * SECS_PER_HOUR;
    s4_err   <= s3_err;
    s4_x1    <= s3_x1;
    s4_sec   <= s3_sec;
  end

  // ------------------------------------------------------------------
  // Stage 5: 1461*yr/4; day within era -> 4d+3; seconds within hour.
  // ------------------------------------------------------------------
  logic [17:0] ty_c;
  logic [23:0] r_c;
  logic [16:0] rem_c;

  always_comb begin
    ty_c  = 18'(s4_yr) * 18'(QUAD_DAYS);
    r_c   = s4_x1 - s4_qm;
    rem_c = s4_sec - s4_h3600;
  end

  logic [15:0] s5_ty;
  logic [22:0] s5_acc;
  logic [16:0] s5_secs;
  logic [17:0] s5_x2;
  logic [11:0] s5_rem;
  logic [6:0]  s5_q;
  logic [4:0]  s5_hour;
  logic        s5_err;

  always_ff @(posedge clk) begin
    s5_mode <= s4_mode;
    s5_ty   <= ty_c[17:2];
    s5_acc  <= s4_acc + s4_tc;
    s5_secs <= s4_secs;
    s5_x2   <= r_c[17:0] | 18'd3;     // 4*floor(r/4) + 3
    s5_rem  <= rem_c[11:0];
    s5_q    <= s4_q;
    s5_hour <= s4_hour;
    s5_err  <= s4_err;
  end

  // ------------------------------------------------------------------
  // Stage 6: day number done; 4-year and minute reciprocals.
  // ------------------------------------------------------------------
  logic [22:0] s6_dn;
  logic [16:0] s6_secs;
  logic [37:0] s6_prod_j;
  logic [24:0] s6_prod_mn;
  logic [17:0] s6_x2;
  logic [11:0] s6_rem;
  logic [6:0]  s6_q;
  logic [4:0]  s6_hour;
  logic        s6_err;

  always_ff @(posedge clk) begin
    s6_mode    <= s5_mode;
    s6_dn      <= s5_acc + 23'(s5_ty);
    s6_secs    <= s5_secs;
    s6_prod_j  <= 38'(s5_x2) * 38'(RECIP_QUAD);
    s6_prod_mn <= 25'(s5_rem) * 25'(RECIP_MIN);
    s6_x2      <= s5_x2;
    s6_rem     <= s5_rem;
    s6_q       <= s5_q;
    s6_hour    <= s5_hour;
    s6_err     <= s5_err;
  end

  // ------------------------------------------------------------------
  // Stage 7: year in 4-year cycle -> 1461*j2; minute -> 60*minute.
  // ------------------------------------------------------------------
  logic [6:0] j2_c;
  logic [5:0] mn_c;

  always_comb begin
    j2_c = s6_prod_j[36:30];
    mn_c = s6_prod_mn[23:18];
  end

  logic [22:0] s7_dn;
  logic [16:0] s7_secs;
  logic [6:0]  s7_j2;
  logic [17:0] s7_j1461;
  logic [5:0]  s7_min;
  logic [11:0] s7_m60;
  logic [17:0] s7_x2;
  logic [11:0] s7_rem;
  logic [6:0]  s7_q;
  logic [4:0]  s7_hour;
  logic        s7_err;

  always_ff @(posedge clk) begin
    s7_mode  <= s6_mode;
    s7_dn    <= s6_dn;
    s7_secs  <= s6_secs;
    s7_j2    <= j2_c;
    s7_j1461 <= 18'(j2_c) * 18'(QUAD_DAYS);
    s7_min   <= mn_c;
    s7_m60   <= 12'(mn_c) * 12'(SECS_PER_MIN);
    s7_x2    <= s6_x2;
    s7_rem   <= s6_rem;
    s7_q     <= s6_q;
    s7_hour  <= s6_hour;
    s7_err   <= s6_err;
  end

  // ------------------------------------------------------------------
  // Stage 8: day within year -> 5*d-3; seconds.
  // ------------------------------------------------------------------
  logic [17:0] d2_c;
  logic [8:0]  d3_c;
  logic [11:0] s_c;

  always_comb begin
    d2_c = s7_x2 - s7_j1461;
    d3_c = 9'(d2_c[10:2]) + 9'd1;    // floor((d2 + 4) / 4)
    s_c  = s7_rem - s7_m60;
  end

  logic [22:0] s8_dn;
  logic [16:0] s8_secs;
  logic [10:0] s8_x3;
  logic [5:0]  s8_sec;
  logic [6:0]  s8_j2;
  logic [5:0]  s8_min;
  logic [6:0]  s8_q;
  logic [4:0]  s8_hour;
  logic        s8_err;

  always_ff @(posedge clk) begin
    s8_mode <= s7_mode;
    s8_dn   <= s7_dn;
    s8_secs <= s7_secs;
    s8_x3   <= 11'(d3_c) * 11'd5 - 11'd3;
    s8_sec  <= s_c[5:0];
    s8_j2   <= s7_j2;
    s8_min  <= s7_min;
    s8_q    <= s7_q;
    s8_hour <= s7_hour;
    s8_err  <= s7_err;
  end

  // ------------------------------------------------------------------
  // Stage 9: month reciprocal.
  // ------------------------------------------------------------------
  logic [22:0] s9_dn;
  logic [16:0] s9_secs;
  logic [23:0] s9_prod_m;
  logic [10:0] s9_x3;
  logic [5:0]  s9_sec;
  logic [6:0]  s9_j2;
  logic [5:0]  s9_min;
  logic [6:0]  s9_q;
  logic [4:0]  s9_hour;
  logic        s9_err;

  always_ff @(posedge clk) begin
    s9_mode   <= s8_mode;
    s9_dn     <= s8_dn;
    s9_secs   <= s8_secs;
    s9_prod_m <= 24'(s8_x3) * 24'(RECIP_MON);
    s9_x3     <= s8_x3;
    s9_sec    <= s8_sec;
    s9_j2     <= s8_j2;
    s9_min    <= s8_min;
    s9_q      <= s8_q;
    s9_hour   <= s8_hour;
    s9_err    <= s8_err;
  end

  // ------------------------------------------------------------------
  // Stage 10: month index -> 153*m; year = 100q + j2.
  // ------------------------------------------------------------------
  logic [3:0] m_c;

  assign m_c = s9_prod_m[23:20];

  logic [22:0] s10_dn;
  logic [16:0] s10_secs;
  logic [3:0]  s10_mon;
  logic [10:0] s10_m153;
  logic [13:0] s10_yr;
  logic [10:0] s10_x3;
  logic [5:0]  s10_sec;
  logic [5:0]  s10_min;
  logic [4:0]  s10_hour;
  logic        s10_err;

  always_ff @(posedge clk) begin
    s10_mode <= s9_mode;
    s10_dn   <= s9_dn;
    s10_secs <= s9_secs;
    s10_mon  <= m_c;
    s10_m153 <= 11'(m_c) * 11'(MON_SPAN);
    s10_yr   <= 14'(s9_q) * 14'(CENTURY) + 14'(s9_j2);
    s10_x3   <= s9_x3;
    s10_sec  <= s9_sec;
    s10_min  <= s9_min;
    s10_hour <= s9_hour;
    s10_err  <= s9_err;
  end

  // ------------------------------------------------------------------
  // Stage 11: remainder within month; back to a January-based year.
  // ------------------------------------------------------------------
  logic [10:0] dd_c;
  logic        late_c;   // index 10/11 is January/February of next year

  always_comb begin
    dd_c   = s10_x3 - s10_m153;
    late_c = (s10_mon >= 4'd10);
  end

  logic [22:0] s11_dn;
  logic [16:0] s11_secs;
  logic [7:0]  s11_dd5;
  logic [3:0]  s11_mon;
  logic [13:0] s11_yr;
  logic [5:0]  s11_sec;
  logic [5:0]  s11_min;
  logic [4:0]  s11_hour;
  logic        s11_err;

  always_ff @(posedge clk) begin
    s11_mode <= s10_mode;
    s11_dn   <= s10_dn;
    s11_secs <= s10_secs;
    s11_dd5  <= dd_c[7:0] + 8'd5;
    s11_mon  <= late_c ? s10_mon - 4'd9 : s10_mon + 4'd3;
    s11_yr   <= s10_yr + 14'(late_c);
    s11_sec  <= s10_sec;
    s11_min  <= s10_min;
    s11_hour <= s10_hour;
    s11_err  <= s10_err;
  end

  // ------------------------------------------------------------------
  // Stage 12: day of month = floor((dd + 5) / 5); output registers.
  // Unused fields of each mode, and all calendar fields on a range
  // error, are forced to zero.
  // ------------------------------------------------------------------
  logic [15:0] day5_c;
  logic        cal_ok_c;

  always_comb begin
    day5_c   = 16'(s11_dd5) * 16'(RECIP_FIVE);
    cal_ok_c = s11_mode && !s11_err;
  end

  always_ff @(posedge clk) begin
    day_number     <= s11_mode ? '0 : s11_dn;
    seconds_of_day <= s11_mode ? '0 : s11_secs;
    year_out       <= cal_ok_c ? s11_yr : '0;
    month_out      <= cal_ok_c ? s11_mon : '0;
    day_out        <= cal_ok_c ? day5_c[14:10] : '0;
    hour_out       <= cal_ok_c ? s11_hour : '0;
    minute_out     <= cal_ok_c ? s11_min : '0;
    second_out     <= cal_ok_c ? s11_sec : '0;
    range_error    <= s11_mode && s11_err;
  end

`ifndef SYNTHESIS
  // Every accepted request comes out as a done strobe
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH done)
    else $error("request not answered after pipeline latency");

  // No result without a matching earlier request
  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, PIPE_DEPTH))
    else $error("result strobe without matching request");

  // Out-of-range day gives only the flag
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (year_out == '0 && month_out == '0 &&
      day_out == '0 && day_number == '0 && seconds_of_day == '0))
    else $error("range error with nonzero fields");

  // In-range day always lands on a real month
  a_month_legal: assert property (@(posedge clk) disable iff (rst)
    (vld[PIPE_DEPTH-2] && s11_mode && !s11_err) |->
      (s11_mon >= 4'd1 && s11_mon <= 4'd12))
    else $error("month out of range in decode path");
`endif

endmodule
